// File: rtl/csx_pkg.sv
// csx_pkg: types, constants and codes shared by the subgraph extraction unit
// no dependencies; compiled before every other file of the block
`default_nettype none

package csx_pkg;

    localparam int MAX_NODES  = 65536;
    localparam int MAX_LINKS  = 16777216;

    localparam int ID_W       = 16;
    localparam int COUNT_W    = 16;
    localparam int WEIGHT_W   = 32;
    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 2;
    localparam int RANK_W     = $clog2(MAX_NODES) + 1;
    localparam int CUM_W      = $clog2(MAX_LINKS) + 1;

    localparam int WORD_W     = 32;
    localparam int BIT_IDX_W  = $clog2(WORD_W);
    localparam int MAP_WORDS  = MAX_NODES / WORD_W;
    localparam int MAP_ADDR_W = $clog2(MAP_WORDS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_MARK     = 2'd0,
        ACT_FINALIZE = 2'd1,
        ACT_HEADER   = 2'd2,
        ACT_LINK     = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_LINK      = 2'd0,
        KIND_EMPTY_ROW = 2'd1,
        KIND_DONE      = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_HEADER,
        S_LINK,
        S_FIN_READ,
        S_FIN_LOAD,
        S_FIN_SCAN,
        S_FIN_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_MARK,
        OP_HEADER,
        OP_LINK,
        OP_FIN_READ,
        OP_FIN_LOAD,
        OP_FIN_BIT,
        OP_FIN_NEXT,
        OP_FIN_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic widx_last;
        logic word_zero;
        logic hdr_emit;
        logic link_emit;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/csx_in_if.sv
// csx_in_if: valid/ready channel carrying one input item
// depends on csx_pkg for field widths
`default_nettype none

interface csx_in_if;
    logic                          valid;
    logic                          ready;
    logic [csx_pkg::ACTION_W-1:0]  action;
    logic [csx_pkg::ID_W-1:0]      node_id;
    logic [csx_pkg::COUNT_W-1:0]   neighbor_count;
    logic [csx_pkg::ID_W-1:0]      target_id;
    logic [csx_pkg::WEIGHT_W-1:0]  weight_bits;

    modport source (
        output valid, action, node_id, neighbor_count, target_id, weight_bits,
        input  ready
    );
    modport sink (
        input  valid, action, node_id, neighbor_count, target_id, weight_bits,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/csx_out_if.sv
// csx_out_if: valid/ready channel carrying one result item
// depends on csx_pkg for field widths
`default_nettype none

interface csx_out_if;
    logic                          valid;
    logic                          ready;
    logic [csx_pkg::KIND_W-1:0]    kind;
    logic [csx_pkg::ID_W-1:0]      new_target;
    logic                          target_outside;
    logic [csx_pkg::WEIGHT_W-1:0]  weight_out;
    logic                          row_end;
    logic [csx_pkg::ID_W-1:0]      new_node;
    logic [csx_pkg::CUM_W-1:0]     deg_sum;
    logic [csx_pkg::RANK_W-1:0]    node_count;

    modport source (
        output valid, kind, new_target, target_outside, weight_out, row_end,
               new_node, deg_sum, node_count,
        input  ready
    );
    modport sink (
        input  valid, kind, new_target, target_outside, weight_out, row_end,
               new_node, deg_sum, node_count,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/csx_ctrl.sv
// csx_ctrl: sequencing state machine of the subgraph extraction unit
// depends on csx_pkg; drives datapath commands, reads datapath status
`default_nettype none

module csx_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic [csx_pkg::ACTION_W-1:0] i_in_action,
    output logic                              o_in_ready,
    input  wire csx_pkg::t_status             i_status,
    output csx_pkg::t_cmd                     o_cmd
);

    csx_pkg::t_state  r_state;
    csx_pkg::t_state  n_state;
    csx_pkg::t_action w_action;

    assign w_action = csx_pkg::t_action'(i_in_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csx_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.op   = csx_pkg::OP_NONE;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            csx_pkg::S_CLEAR: begin
                o_cmd.op = csx_pkg::OP_CLEAR;
                if (i_status.widx_last) begin
                    n_state = csx_pkg::S_IDLE;
                end
            end
            csx_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = csx_pkg::OP_ACCEPT;
                    unique case (w_action)
                        csx_pkg::ACT_MARK:     n_state = csx_pkg::S_MARK;
                        csx_pkg::ACT_FINALIZE: n_state = csx_pkg::S_FIN_READ;
                        csx_pkg::ACT_HEADER:   n_state = csx_pkg::S_HEADER;
                        csx_pkg::ACT_LINK:     n_state = csx_pkg::S_LINK;
                        default:               n_state = csx_pkg::S_IDLE;
                    endcase
                end
            end
            csx_pkg::S_MARK: begin
                o_cmd.op = csx_pkg::OP_MARK;
                n_state  = csx_pkg::S_IDLE;
            end
            csx_pkg::S_HEADER: begin
                if (!i_status.hdr_emit || i_status.out_free) begin
                    o_cmd.op   = csx_pkg::OP_HEADER;
                    o_cmd.emit = i_status.hdr_emit;
                    n_state    = csx_pkg::S_IDLE;
                end
            end
            csx_pkg::S_LINK: begin
                if (!i_status.link_emit || i_status.out_free) begin
                    o_cmd.op   = csx_pkg::OP_LINK;
                    o_cmd.emit = i_status.link_emit;
                    n_state    = csx_pkg::S_IDLE;
                end
            end
            csx_pkg::S_FIN_READ: begin
                o_cmd.op = csx_pkg::OP_FIN_READ;
                n_state  = csx_pkg::S_FIN_LOAD;
            end
            csx_pkg::S_FIN_LOAD: begin
                o_cmd.op = csx_pkg::OP_FIN_LOAD;
                n_state  = csx_pkg::S_FIN_SCAN;
            end
            csx_pkg::S_FIN_SCAN: begin
                if (!i_status.word_zero) begin
                    o_cmd.op = csx_pkg::OP_FIN_BIT;
                end else if (i_status.widx_last) begin
                    n_state = csx_pkg::S_FIN_DONE;
                end else begin
                    o_cmd.op = csx_pkg::OP_FIN_NEXT;
                    n_state  = csx_pkg::S_FIN_READ;
                end
            end
            csx_pkg::S_FIN_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op   = csx_pkg::OP_FIN_DONE;
                    o_cmd.emit = 1'b1;
                    n_state    = csx_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csx_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/csx_datapath.sv
// csx_datapath: member bitmap, new id table, row state and result register
// depends on csx_pkg; steered by csx_ctrl through t_cmd and t_status
`default_nettype none

module csx_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire csx_pkg::t_cmd                i_cmd,
    output csx_pkg::t_status                  o_status,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    input  wire logic [csx_pkg::ACTION_W-1:0] i_action,
    input  wire logic [csx_pkg::ID_W-1:0]     i_node_id,
    input  wire logic [csx_pkg::COUNT_W-1:0]  i_neighbor_count,
    input  wire logic [csx_pkg::ID_W-1:0]     i_target_id,
    input  wire logic [csx_pkg::WEIGHT_W-1:0] i_weight_bits,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [csx_pkg::KIND_W-1:0]        o_kind,
    output logic [csx_pkg::ID_W-1:0]          o_new_target,
    output logic                              o_target_outside,
    output logic [csx_pkg::WEIGHT_W-1:0]      o_weight_out,
    output logic                              o_row_end,
    output logic [csx_pkg::ID_W-1:0]          o_new_node,
    output logic [csx_pkg::CUM_W-1:0]         o_deg_sum,
    output logic [csx_pkg::RANK_W-1:0]        o_node_count
);

    function automatic logic [csx_pkg::BIT_IDX_W-1:0] f_low_bit(
        input logic [csx_pkg::WORD_W-1:0] w
    );
        logic [csx_pkg::BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = csx_pkg::WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = csx_pkg::BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // memories
    logic [csx_pkg::WORD_W-1:0] mem_map [csx_pkg::MAP_WORDS];
    logic [csx_pkg::ID_W-1:0]   mem_id  [csx_pkg::MAX_NODES];

    // captured item
    logic [csx_pkg::ID_W-1:0]     r_node;
    logic [csx_pkg::COUNT_W-1:0]  r_count;
    logic [csx_pkg::ID_W-1:0]     r_target;
    logic [csx_pkg::WEIGHT_W-1:0] r_weight;
    logic [csx_pkg::WORD_W-1:0]   r_map_rdata;
    logic [csx_pkg::ID_W-1:0]     r_id_rdata;
    logic [csx_pkg::WORD_W-1:0]   r_word;

    // control state
    logic [csx_pkg::MAP_ADDR_W-1:0] r_widx,       n_widx;
    logic [csx_pkg::RANK_W-1:0]     r_rank,       n_rank;
    logic                           r_row_member, n_row_member;
    logic [csx_pkg::ID_W-1:0]       r_row_id,     n_row_id;
    logic [csx_pkg::COUNT_W-1:0]    r_links_left, n_links_left;
    logic [csx_pkg::CUM_W-1:0]      r_cum,        n_cum;
    logic                           r_weights_on;
    logic                           r_out_valid,  n_out_valid;

    // result register
    logic [csx_pkg::KIND_W-1:0]   r_kind,    n_kind;
    logic [csx_pkg::ID_W-1:0]     r_new_tgt, n_new_tgt;
    logic                         r_outside, n_outside;
    logic [csx_pkg::WEIGHT_W-1:0] r_wout,    n_wout;
    logic                         r_row_end, n_row_end;
    logic [csx_pkg::ID_W-1:0]     r_new_nd,  n_new_nd;
    logic [csx_pkg::CUM_W-1:0]    r_cum_deg, n_cum_deg;
    logic [csx_pkg::RANK_W-1:0]   r_ncount,  n_ncount;

    logic                             w_accept;
    logic [csx_pkg::ID_W-1:0]         w_sel_id;
    logic                             w_map_re;
    logic [csx_pkg::MAP_ADDR_W-1:0]   w_map_raddr;
    logic                             w_map_we;
    logic [csx_pkg::MAP_ADDR_W-1:0]   w_map_waddr;
    logic [csx_pkg::WORD_W-1:0]       w_map_wdata;
    logic                             w_id_we;
    logic [csx_pkg::ID_W-1:0]         w_id_waddr;
    logic [csx_pkg::BIT_IDX_W-1:0]    w_low;
    logic                             w_hdr_member;
    logic                             w_tgt_member;
    logic                             w_link_live;
    logic                             w_last_link;
    logic [csx_pkg::CUM_W-1:0]        w_cum_next;
    logic                             w_out_free;

    assign w_accept    = (i_cmd.op == csx_pkg::OP_ACCEPT);
    assign w_sel_id    = (csx_pkg::t_action'(i_action) == csx_pkg::ACT_LINK) ?
                         i_target_id : i_node_id;
    assign w_map_re    = w_accept || (i_cmd.op == csx_pkg::OP_FIN_READ);
    assign w_map_raddr = (i_cmd.op == csx_pkg::OP_FIN_READ) ? r_widx :
                         w_sel_id[csx_pkg::ID_W-1:csx_pkg::BIT_IDX_W];
    assign w_map_we    = (i_cmd.op == csx_pkg::OP_CLEAR) || (i_cmd.op == csx_pkg::OP_MARK);
    assign w_map_waddr = (i_cmd.op == csx_pkg::OP_CLEAR) ? r_widx :
                         r_node[csx_pkg::ID_W-1:csx_pkg::BIT_IDX_W];
    assign w_map_wdata = (i_cmd.op == csx_pkg::OP_CLEAR) ? '0 :
                         (r_map_rdata | (csx_pkg::WORD_W'(1) << r_node[csx_pkg::BIT_IDX_W-1:0]));
    assign w_low       = f_low_bit(r_word);
    assign w_id_we     = (i_cmd.op == csx_pkg::OP_FIN_BIT);
    assign w_id_waddr  = {r_widx, w_low};

    assign w_hdr_member = r_map_rdata[r_node[csx_pkg::BIT_IDX_W-1:0]];
    assign w_tgt_member = r_map_rdata[r_target[csx_pkg::BIT_IDX_W-1:0]];
    assign w_link_live  = (r_links_left != '0);
    assign w_last_link  = (r_links_left == csx_pkg::COUNT_W'(1));
    assign w_cum_next   = (r_cum < csx_pkg::CUM_W'(csx_pkg::MAX_LINKS)) ?
                          (r_cum + csx_pkg::CUM_W'(1)) : r_cum;
    assign w_out_free   = !r_out_valid || i_out_ready;

    assign o_status.widx_last = (r_widx == csx_pkg::MAP_ADDR_W'(csx_pkg::MAP_WORDS - 1));
    assign o_status.word_zero = (r_word == '0);
    assign o_status.hdr_emit  = w_hdr_member && (r_count == '0);
    assign o_status.link_emit = w_link_live && r_row_member;
    assign o_status.out_free  = w_out_free;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (w_map_re) begin
            r_map_rdata <= mem_map[w_map_raddr];
        end
        if (w_map_we) begin
            mem_map[w_map_waddr] <= w_map_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id_rdata <= mem_id[w_sel_id];
        end
        if (w_id_we) begin
            mem_id[w_id_waddr] <= r_rank[csx_pkg::ID_W-1:0];
        end
    end

    // item capture and bitmap word under scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_node   <= i_node_id;
            r_count  <= i_neighbor_count;
            r_target <= i_target_id;
            r_weight <= i_weight_bits;
        end
        if (i_cmd.op == csx_pkg::OP_FIN_LOAD) begin
            r_word <= r_map_rdata;
        end else if (i_cmd.op == csx_pkg::OP_FIN_BIT) begin
            r_word <= r_word & (r_word - csx_pkg::WORD_W'(1));
        end
    end

    always_comb begin
        n_widx       = r_widx;
        n_rank       = r_rank;
        n_row_member = r_row_member;
        n_row_id     = r_row_id;
        n_links_left = r_links_left;
        n_cum        = r_cum;
        n_kind       = r_kind;
        n_new_tgt    = r_new_tgt;
        n_outside    = r_outside;
        n_wout       = r_wout;
        n_row_end    = r_row_end;
        n_new_nd     = r_new_nd;
        n_cum_deg    = r_cum_deg;
        n_ncount     = r_ncount;
        n_out_valid  = r_out_valid && !i_out_ready;

        case (i_cmd.op)
            csx_pkg::OP_CLEAR, csx_pkg::OP_FIN_NEXT: begin
                n_widx = r_widx + csx_pkg::MAP_ADDR_W'(1);
            end
            csx_pkg::OP_ACCEPT: begin
                if (csx_pkg::t_action'(i_action) == csx_pkg::ACT_FINALIZE) begin
                    n_widx       = '0;
                    n_rank       = '0;
                    n_row_member = 1'b0;
                    n_row_id     = '0;
                    n_links_left = '0;
                    n_cum        = '0;
                end
            end
            csx_pkg::OP_FIN_BIT: begin
                n_rank = r_rank + csx_pkg::RANK_W'(1);
            end
            csx_pkg::OP_HEADER: begin
                n_row_member = w_hdr_member;
                n_row_id     = w_hdr_member ? r_id_rdata : '0;
                n_links_left = r_count;
            end
            csx_pkg::OP_LINK: begin
                if (w_link_live) begin
                    n_links_left = r_links_left - csx_pkg::COUNT_W'(1);
                    if (r_row_member) begin
                        n_cum = w_cum_next;
                    end
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_new_tgt   = '0;
            n_outside   = 1'b0;
            n_wout      = '0;
            n_row_end   = 1'b0;
            n_new_nd    = '0;
            n_cum_deg   = '0;
            n_ncount    = '0;
            case (i_cmd.op)
                csx_pkg::OP_HEADER: begin
                    n_kind    = csx_pkg::KIND_EMPTY_ROW;
                    n_row_end = 1'b1;
                    n_new_nd  = r_id_rdata;
                    n_cum_deg = r_cum;
                end
                csx_pkg::OP_LINK: begin
                    n_kind    = csx_pkg::KIND_LINK;
                    n_new_tgt = w_tgt_member ? r_id_rdata : '0;
                    n_outside = !w_tgt_member;
                    n_wout    = r_weights_on ? r_weight : '0;
                    n_row_end = w_last_link;
                    n_new_nd  = r_row_id;
                    n_cum_deg = w_last_link ? w_cum_next : '0;
                end
                default: begin
                    n_kind   = csx_pkg::KIND_DONE;
                    n_ncount = r_rank;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx       <= '0;
            r_rank       <= '0;
            r_row_member <= 1'b0;
            r_row_id     <= '0;
            r_links_left <= '0;
            r_cum        <= '0;
            r_weights_on <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_widx       <= n_widx;
            r_rank       <= n_rank;
            r_row_member <= n_row_member;
            r_row_id     <= n_row_id;
            r_links_left <= n_links_left;
            r_cum        <= n_cum;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_weights_on <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_new_tgt <= n_new_tgt;
        r_outside <= n_outside;
        r_wout    <= n_wout;
        r_row_end <= n_row_end;
        r_new_nd  <= n_new_nd;
        r_cum_deg <= n_cum_deg;
        r_ncount  <= n_ncount;
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_new_target     = r_new_tgt;
    assign o_target_outside = r_outside;
    assign o_weight_out     = r_wout;
    assign o_row_end        = r_row_end;
    assign o_new_node       = r_new_nd;
    assign o_deg_sum        = r_cum_deg;
    assign o_node_count     = r_ncount;

endmodule

`default_nettype wire

// File: rtl/csr_subgraph_extract_unit.sv
// csr_subgraph_extract_unit: top level of the csr induced subgraph extractor
// depends on csx_pkg, csx_in_if, csx_out_if, csx_ctrl and csx_datapath
//
//   port        dir   flow       contents
//   i_item      in    valid/rdy  action, node_id, neighbor_count, target_id, weight_bits
//   o_result    out   valid/rdy  kind, new_target, target_outside, weight_out, row_end,
//                                new_node, deg_sum, node_count
//   i_cfg_we    in    write      weights_on taken from i_cfg_wdata
//
// mark, row header and link each read the bitmap word and id table when the item is accepted,
// then update the bitmap or row state and, for row header and link, load the result register
// finalize reads, loads and scans each of the 2048 bitmap words, then emits a done result
// after reset the bitmap is cleared one word per cycle, all 2048 words, with ready low
// the result register holds a transaction while the next one is taken; a pending result
// waits in its state until the register is free
`default_nettype none

module csr_subgraph_extract_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    csx_in_if.sink     i_item,
    csx_out_if.source  o_result,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    csx_pkg::t_cmd    w_cmd;
    csx_pkg::t_status w_status;

    csx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_action (i_item.action),
        .o_in_ready  (i_item.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    csx_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_item.action),
        .i_node_id        (i_item.node_id),
        .i_neighbor_count (i_item.neighbor_count),
        .i_target_id      (i_item.target_id),
        .i_weight_bits    (i_item.weight_bits),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_kind           (o_result.kind),
        .o_new_target     (o_result.new_target),
        .o_target_outside (o_result.target_outside),
        .o_weight_out     (o_result.weight_out),
        .o_row_end        (o_result.row_end),
        .o_new_node       (o_result.new_node),
        .o_deg_sum        (o_result.deg_sum),
        .o_node_count     (o_result.node_count)
    );

endmodule

`default_nettype wire
